### hw/rtl/hdw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat delay watchdog package
// Shared types, event codes, register indexes and constants.
// ----------------------------------------------------------------------------
package hdw_pkg;

  localparam logic [10:0] MaxLeaves        = 11'd1024;
  localparam logic [19:0] MinIntervalMs    = 20'd100;
  localparam logic [19:0] DefIntervalMs    = 20'd1000;
  localparam logic [9:0]  DefFailIntervals = 10'd10;
  localparam logic [19:0] NsPerMs          = 20'd1000000;
  localparam logic [39:0] DefaultWaitNs    = 40'd1000000000;
  localparam logic [39:0] BoostWaitNs      = 40'd100000000;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_WRITE_OK   = 2'd1,
    OP_WRITE_FAIL = 2'd2,
    OP_START      = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    CFG_INTERVAL_MS    = 1'b0,
    CFG_FAIL_INTERVALS = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_TGT,
    ST_PRE,
    ST_DSEL,
    ST_DIV,
    ST_POST,
    ST_DONE
  } fsm_state_t;

  typedef struct packed {
    op_t         op;
    logic [62:0] now_ns;
    logic        multihost;
    logic        suspended;
    logic [10:0] leaf_count;
  } in_item_t;

  typedef struct packed {
    logic [62:0] delay_ns;
    logic        suspend_now;
    logic        issue_write;
    logic [39:0] wait_ns;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic calc_ins;
    logic calc_tgt;
    logic pre;
    logic div_start;
    logic post;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage

### hw/rtl/hdw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat delay watchdog divider
// Restoring divider, one quotient bit per cycle, 40-bit dividend by leaf count.
// ----------------------------------------------------------------------------
module hdw_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [10:0] divisor,
  output logic [39:0] quotient,
  output logic        done
);

  localparam int unsigned DivSteps = 40;

  logic        busy;
  logic [5:0]  cnt;
  logic [10:0] rem;
  logic [10:0] dvs;
  logic [39:0] quo;
  logic [11:0] trial;

  assign trial    = {rem, quo[39]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(DivSteps - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= 11'(trial - {1'b0, dvs});
        quo <= {quo[38:0], 1'b1};
      end else begin
        rem <= trial[10:0];
        quo <= {quo[38:0], 1'b0};
      end
    end
  end

  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider did not go busy after start");

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a finished iteration");

endmodule

### hw/rtl/hdw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat delay watchdog datapath
// Configuration and monitor state, arithmetic steps and the result register.
// ----------------------------------------------------------------------------
module hdw_dp (
  input  logic              clk,
  input  logic              rst,
  input  hdw_pkg::cmd_t     cmd,
  output hdw_pkg::status_t  sts,
  input  hdw_pkg::in_item_t in_data,
  input  logic              cfg_valid,
  input  logic [0:0]        cfg_index,
  input  logic [19:0]       cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hdw_pkg::out_item_t out_data
);

  // Configuration registers.
  logic [19:0] interval_ms;
  logic [9:0]  fail_limit;

  // Monitor state.
  logic [62:0] last_write_time;
  logic [62:0] avg_delay;
  logic [49:0] fail_window_ns;
  logic [19:0] prev_interval_ms;
  logic [9:0]  prev_fail_count;
  logic        prev_multihost;
  logic        prev_suspended;
  logic [15:0] boost_ticks;

  // Working registers of the current transaction.
  hdw_pkg::op_t op;
  logic [62:0] now_ns;
  logic        mh;
  logic        su;
  logic [10:0] leaves;
  logic [19:0] ims;
  logic [9:0]  fi;
  logic [39:0] ins;
  logic [49:0] target;
  logic [62:0] elapsed_ns;
  logic [56:0] dec;
  logic        shorter;
  logic        res_susp;
  logic        res_issue;
  logic [39:0] res_wait;

  // Combinational helpers.
  logic [10:0] leaves_c;
  logic [19:0] ims_c;
  logic [9:0]  fi_c;
  logic [54:0] fw31;
  logic [55:0] fw_sum;
  logic [16:0] boost_sum;
  logic [15:0] boost_sat;
  logic        changed;
  logic [63:0] diff_rnd;
  logic [62:0] cand;
  logic        rearm;
  logic        drop;
  logic [62:0] susp_elapsed;
  logic [39:0] div_dividend;
  logic [39:0] quotient;
  logic        div_done;

  always_comb begin
    if (in_data.leaf_count == '0) begin
      leaves_c = 11'd1;
    end else if (in_data.leaf_count > hdw_pkg::MaxLeaves) begin
      leaves_c = hdw_pkg::MaxLeaves;
    end else begin
      leaves_c = in_data.leaf_count;
    end
  end

  assign ims_c = (interval_ms < hdw_pkg::MinIntervalMs) ? hdw_pkg::MinIntervalMs : interval_ms;
  assign fi_c  = (fail_limit == 10'd1) ? 10'd2 : fail_limit;

  // Smoothed window: (31 * window + target) / 32.
  assign fw31      = {fail_window_ns, 5'b0} - {5'd0, fail_window_ns};
  assign fw_sum    = {1'b0, fw31} + {6'd0, target};
  assign boost_sum = {1'b0, boost_ticks} + {6'd0, leaves};
  assign boost_sat = boost_sum[16] ? 16'hFFFF : boost_sum[15:0];
  assign changed   = (ims != prev_interval_ms) || (fi != prev_fail_count);

  // Rounded-up step toward the shorter delay: ceil((avg - d) / 128).
  assign diff_rnd = ({1'b0, avg_delay} - {1'b0, elapsed_ns}) + 64'd127;
  assign cand     = avg_delay - {6'd0, dec};

  assign rearm        = (!prev_multihost && mh) || (prev_suspended && !su);
  assign drop         = prev_multihost && !mh;
  assign susp_elapsed = rearm ? '0 : elapsed_ns;

  assign div_dividend = ((op == hdw_pkg::OP_TICK) && (boost_ticks != '0)) ?
                        hdw_pkg::BoostWaitNs : ins;

  hdw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (leaves),
    .quotient (quotient),
    .done     (div_done)
  );

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || !out_stall;

  // Configuration and monitor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ms      <= hdw_pkg::DefIntervalMs;
      fail_limit       <= hdw_pkg::DefFailIntervals;
      last_write_time  <= '0;
      avg_delay        <= '0;
      fail_window_ns   <= '0;
      prev_interval_ms <= '0;
      prev_fail_count  <= '0;
      prev_multihost   <= 1'b0;
      prev_suspended   <= 1'b0;
      boost_ticks      <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          hdw_pkg::CFG_INTERVAL_MS:    interval_ms <= cfg_data;
          hdw_pkg::CFG_FAIL_INTERVALS: fail_limit  <= cfg_data[9:0];
          default: ;
        endcase
      end

      if (cmd.pre) begin
        case (op)
          hdw_pkg::OP_START: begin
            last_write_time  <= now_ns;
            avg_delay        <= {23'd0, ins};
            fail_window_ns   <= target;
            prev_interval_ms <= ims;
            prev_fail_count  <= fi;
            prev_multihost   <= mh;
            prev_suspended   <= su;
            boost_ticks      <= '0;
          end
          hdw_pkg::OP_WRITE_OK, hdw_pkg::OP_WRITE_FAIL: begin
            if (!mh) begin
              avg_delay <= '0;
            end else if (elapsed_ns > avg_delay) begin
              avg_delay <= elapsed_ns;
            end
          end
          default: begin
            fail_window_ns <= (target < fail_window_ns) ? fw_sum[54:5] : target;
            if (changed) begin
              boost_ticks <= boost_sat;
            end
          end
        endcase
      end

      if (cmd.post) begin
        case (op)
          hdw_pkg::OP_WRITE_OK: begin
            if (mh) begin
              last_write_time <= now_ns;
              if (shorter) begin
                avg_delay <= (cand > {23'd0, quotient}) ? cand : {23'd0, quotient};
              end
            end
          end
          hdw_pkg::OP_TICK: begin
            prev_multihost   <= mh;
            prev_suspended   <= su;
            prev_interval_ms <= ims;
            prev_fail_count  <= fi;
            if (rearm) begin
              last_write_time <= now_ns;
              avg_delay       <= {23'd0, ins};
            end
            // Losing protection wins over a resume in the same tick.
            if (drop) begin
              avg_delay <= '0;
            end
            if (boost_ticks != '0) begin
              boost_ticks <= boost_ticks - 16'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op     <= in_data.op;
      now_ns <= in_data.now_ns;
      mh     <= in_data.multihost;
      su     <= in_data.suspended;
      leaves <= leaves_c;
      ims    <= ims_c;
      fi     <= fi_c;
    end
    if (cmd.calc_ins) begin
      ins        <= {20'd0, ims} * {20'd0, hdw_pkg::NsPerMs};
      elapsed_ns <= (now_ns > last_write_time) ? (now_ns - last_write_time) : '0;
    end
    if (cmd.calc_tgt) begin
      target <= {40'd0, fi} * {10'd0, ins};
    end
    if (cmd.div_start) begin
      dec     <= diff_rnd[63:7];
      shorter <= elapsed_ns < avg_delay;
    end
    if (cmd.post) begin
      res_susp  <= 1'b0;
      res_issue <= 1'b0;
      res_wait  <= '0;
      if (op == hdw_pkg::OP_TICK) begin
        res_susp  <= mh && !su && (fi != '0) && (susp_elapsed > {13'd0, fail_window_ns});
        res_issue <= mh && !su;
        res_wait  <= ((boost_ticks != '0) || mh) ? quotient : hdw_pkg::DefaultWaitNs;
      end
    end
    if (cmd.load_out) begin
      out_data.delay_ns    <= avg_delay;
      out_data.suspend_now <= res_susp;
      out_data.issue_write <= res_issue;
      out_data.wait_ns     <= res_wait;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_load_into_free : assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid || !out_stall)
    else $error("result register overwritten while a transaction was stalled");

endmodule

### hw/rtl/hdw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat delay watchdog controller
// Sequences the datapath steps for one transaction at a time.
// ----------------------------------------------------------------------------
module hdw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  hdw_pkg::status_t sts,
  output hdw_pkg::cmd_t    cmd
);

  hdw_pkg::fsm_state_t state;
  hdw_pkg::fsm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hdw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      hdw_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = hdw_pkg::ST_INS;
        end
      end
      hdw_pkg::ST_INS: begin
        cmd.calc_ins = 1'b1;
        state_next   = hdw_pkg::ST_TGT;
      end
      hdw_pkg::ST_TGT: begin
        cmd.calc_tgt = 1'b1;
        state_next   = hdw_pkg::ST_PRE;
      end
      hdw_pkg::ST_PRE: begin
        cmd.pre    = 1'b1;
        state_next = hdw_pkg::ST_DSEL;
      end
      hdw_pkg::ST_DSEL: begin
        cmd.div_start = 1'b1;
        state_next    = hdw_pkg::ST_DIV;
      end
      hdw_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_next = hdw_pkg::ST_POST;
        end
      end
      hdw_pkg::ST_POST: begin
        cmd.post   = 1'b1;
        state_next = hdw_pkg::ST_DONE;
      end
      hdw_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = hdw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hdw_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == hdw_pkg::ST_INS)
    else $error("accepted transaction did not start processing");

  a_div_wait : assert property (@(posedge clk) disable iff (rst)
    (state == hdw_pkg::ST_DIV) && !sts.div_done |=> state == hdw_pkg::ST_DIV)
    else $error("controller left the divide step before the quotient was ready");

endmodule

### hw/rtl/heartbeat_delay_watchdog_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heartbeat delay watchdog core
// Liveness monitor giving the averaged heartbeat delay, suspension flag and
// next tick wait for each start, tick or write event.
// ----------------------------------------------------------------------------
// Each event transaction produces exactly one result. The core handles one
// transaction at a time and accepts the next event only after the result of
// the last one is loaded. The interval is split over the leaf count in a
// bit-serial divider, around which sit the multiply, compare and update
// steps. A finished result sits in an output register, so a stalled
// consumer only holds the core in its final step. Configuration writes are
// taken in any cycle and should be issued only while no event is in flight.
module heartbeat_delay_watchdog_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hdw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hdw_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  hdw_pkg::cmd_t    cmd;
  hdw_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  hdw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hdw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
